[sv/mesm_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mesm_pkg
// Shared types and constants of the motor encoder speed meter.
// ---------------------------------------------------------------------------
package mesm_pkg;

   // Item commands
   typedef enum logic [1:0] {
      CMD_EDGE  = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_DRIVE = 2'd2
   } cmd_type;

   // Configuration space: one word, rpm_scale
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_WORD_RPM_SCALE = 1'b0;   // paddr[2]

   // Fixed field widths
   localparam int SCALE_W  = 16;
   localparam int SPEED_W  = 16;
   localparam int DRIVE_W  = 9;
   localparam int DUTY_W   = 8;
   localparam int RPM_FRAC = 8;                  // Q8.8 scale

   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1500;

   // Drive clamp: the one code below -255
   localparam logic signed [DRIVE_W-1:0] DRIVE_RAW_MIN = 9'sh100;   // -256
   localparam logic signed [DRIVE_W-1:0] DRIVE_CLAMP   = 9'sh101;   // -255

   // Moving averages, depth 2**LOG2
   localparam int DELTA_AVG_LOG2 = 3;
   localparam int SPEED_AVG_LOG2 = 3;

   // Control that travels with each beat down the pipeline
   typedef struct packed {
      logic                        tick;    // sample tick
      logic                        clr;     // drive started from stop
      logic signed [DRIVE_W-1:0]   drive;   // drive after this item
   } stage_ctl_type;

endpackage

[sv/mesm_avg_ring.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mesm_avg_ring
// Moving-average store: a ring of 2**LOG2_DEPTH values and its running sum.
// sum_next shows the sum after this cycle's push or clear.
// ---------------------------------------------------------------------------
module mesm_avg_ring
   import mesm_pkg::*;
#(
   parameter int WIDTH      = 16,
   parameter int LOG2_DEPTH = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  clear,
   input  logic                                  push,
   input  logic signed [WIDTH-1:0]               value,
   output logic signed [WIDTH+LOG2_DEPTH-1:0]    sum_next
);

   localparam int DEPTH = 1 << LOG2_DEPTH;
   localparam int SUM_W = WIDTH + LOG2_DEPTH;

   logic signed [WIDTH-1:0]   ring_ff [DEPTH];
   logic [LOG2_DEPTH-1:0]     idx_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SUM_W-1:0]   value_ext;
   logic signed [SUM_W-1:0]   oldest_ext;

   // Replace the oldest entry in the running sum
   always_comb begin
      value_ext  = SUM_W'(value);
      oldest_ext = SUM_W'(ring_ff[idx_ff]);
      if (clear) begin
         sum_next = '0;
      end else if (push) begin
         sum_next = sum_ff + value_ext - oldest_ext;
      end else begin
         sum_next = sum_ff;
      end
   end

   // Ring, index and sum
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
         idx_ff <= '0;
         sum_ff <= '0;
      end else if (push) begin
         ring_ff[idx_ff] <= value;
         idx_ff          <= idx_ff + LOG2_DEPTH'(1);
         sum_ff          <= sum_next;
      end
   end

endmodule

[sv/motor_encoder_speed_meter_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor_encoder_speed_meter_unit
// One motor channel: quadrature pulse counter, two moving averages with
// rpm scaling in between, and the drive duty / direction lines.
// ---------------------------------------------------------------------------
//  Channel   Ports                                   Beat
//  req       req_valid/ready, command, channel_b,    one item
//            drive_value
//  rsp       rsp_valid/ready, speed_rpm, duty,       one result per item
//            dir_forward, dir_reverse
//  csr       APB: psel, penable, pwrite, paddr,      rpm_scale at 0x0
//            pwdata, prdata, pready
//
//  Five-stage pipeline, one item per cycle while the output is not held.
//  Stage 1 updates the counter and the pulse-delta average, 2 divides the sum,
//  3 multiplies by rpm_scale, 4 scales and saturates, 5 runs the rpm average.
//  Each stage holds its beat while the next one is full; empty stages still
//  fill, so input keeps flowing while a result waits at the output until all are full.
//  Synchronous reset clears counter, drive, averages, speed and the pipeline; no clearing pass.
// ---------------------------------------------------------------------------
module motor_encoder_speed_meter_unit
   import mesm_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input items
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_command,
   input  logic                          req_channel_b,
   input  logic signed [DRIVE_W-1:0]     req_drive_value,
   // Results
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SPEED_W-1:0]     rsp_speed_rpm,
   output logic [DUTY_W-1:0]             rsp_duty,
   output logic                          rsp_dir_forward,
   output logic                          rsp_dir_reverse,
   // Configuration
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [CSR_DATA_W-1:0]         csr_pwdata,
   output logic [CSR_DATA_W-1:0]         csr_prdata,
   output logic                          csr_pready
);

   localparam int CW     = COUNT_WIDTH;
   localparam int DSUM_W = CW + DELTA_AVG_LOG2;
   localparam int PROD_W = CW + SCALE_W + 1;
   localparam int RPMF_W = PROD_W - RPM_FRAC;
   localparam int SSUM_W = SPEED_W + SPEED_AVG_LOG2;
   localparam logic [CW-1:0] COUNT_ONE = CW'(1);

   // ---------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------
   logic [SCALE_W-1:0] rpm_scale_ff;
   logic               csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rpm_scale_ff <= SCALE_RESET;
      end else if (csr_write && (csr_paddr[2] == CSR_WORD_RPM_SCALE)) begin
         rpm_scale_ff <= csr_pwdata[SCALE_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_WORD_RPM_SCALE) begin
         csr_prdata = CSR_DATA_W'(rpm_scale_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline flow: a stage takes a beat when it is empty or moves on
   // ---------------------------------------------------------------------
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;
   logic req_accept;

   assign s5_rdy     = !s5_vld_ff || rsp_ready;
   assign s4_rdy     = !s4_vld_ff || s5_rdy;
   assign s3_rdy     = !s3_vld_ff || s4_rdy;
   assign s2_rdy     = !s2_vld_ff || s3_rdy;
   assign s1_rdy     = !s1_vld_ff || s2_rdy;
   assign req_ready  = s1_rdy;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = s5_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_vld_ff <= req_valid;
         if (s2_rdy) s2_vld_ff <= s1_vld_ff;
         if (s3_rdy) s3_vld_ff <= s2_vld_ff;
         if (s4_rdy) s4_vld_ff <= s3_vld_ff;
         if (s5_rdy) s5_vld_ff <= s4_vld_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: counter, snapshot, drive and pulse-delta average
   // ---------------------------------------------------------------------
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                snapshot_ff, snapshot_in;
   logic signed [DRIVE_W-1:0]    drive_ff, drive_in;
   logic signed [DRIVE_W-1:0]    drive_clamped;
   logic signed [CW-1:0]         delta;
   logic                         is_tick;
   logic                         start_drive;
   logic signed [DSUM_W-1:0]     dsum_next;
   stage_ctl_type                s1_ctl_ff;
   logic signed [DSUM_W-1:0]     s1_dsum_ff;

   always_comb begin
      count_in      = count_ff;
      snapshot_in   = snapshot_ff;
      drive_in      = drive_ff;
      is_tick       = 1'b0;
      start_drive   = 1'b0;
      delta         = $signed(count_ff - snapshot_ff);
      drive_clamped = (req_drive_value == DRIVE_RAW_MIN) ? DRIVE_CLAMP
                                                         : req_drive_value;
      unique case (cmd_type'(req_command))
         CMD_EDGE: begin
            count_in = req_channel_b ? count_ff + COUNT_ONE : count_ff - COUNT_ONE;
         end
         CMD_TICK: begin
            is_tick     = 1'b1;
            snapshot_in = count_ff;
         end
         CMD_DRIVE: begin
            drive_in = drive_clamped;
            // Start from stop restarts the measurement
            if ((drive_ff == '0) && (drive_clamped != '0)) begin
               start_drive = 1'b1;
               count_in    = '0;
               snapshot_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         snapshot_ff <= '0;
         drive_ff    <= '0;
      end else if (req_accept) begin
         count_ff    <= count_in;
         snapshot_ff <= snapshot_in;
         drive_ff    <= drive_in;
      end
   end

   mesm_avg_ring #(
      .WIDTH      (CW),
      .LOG2_DEPTH (DELTA_AVG_LOG2)
   ) u_delta_avg (
      .clock    (clock),
      .reset    (reset),
      .clear    (req_accept && start_drive),
      .push     (req_accept && is_tick),
      .value    (delta),
      .sum_next (dsum_next)
   );

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ctl_ff.tick  <= is_tick;
         s1_ctl_ff.clr   <= start_drive;
         s1_ctl_ff.drive <= drive_in;
         s1_dsum_ff      <= dsum_next;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: divide the delta sum by the depth, toward zero
   // ---------------------------------------------------------------------
   logic signed [DSUM_W-1:0] dsum_adj;
   stage_ctl_type            s2_ctl_ff;
   logic signed [CW-1:0]     s2_avg_ff;

   assign dsum_adj = s1_dsum_ff + $signed({{(DSUM_W-DELTA_AVG_LOG2){1'b0}},
                                           {DELTA_AVG_LOG2{s1_dsum_ff[DSUM_W-1]}}});

   always_ff @(posedge clock) begin
      if (s2_rdy && s1_vld_ff) begin
         s2_ctl_ff <= s1_ctl_ff;
         s2_avg_ff <= dsum_adj[DSUM_W-1:DELTA_AVG_LOG2];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: average times rpm_scale
   // ---------------------------------------------------------------------
   logic signed [PROD_W-1:0] prod;
   stage_ctl_type            s3_ctl_ff;
   logic signed [PROD_W-1:0] s3_prod_ff;

   assign prod = PROD_W'(s2_avg_ff) * PROD_W'($signed({1'b0, rpm_scale_ff}));

   always_ff @(posedge clock) begin
      if (s3_rdy && s2_vld_ff) begin
         s3_ctl_ff  <= s2_ctl_ff;
         s3_prod_ff <= prod;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: drop the Q8.8 fraction toward zero, saturate to 16 bits
   // ---------------------------------------------------------------------
   logic signed [PROD_W-1:0]   prod_adj;
   logic signed [RPMF_W-1:0]   rpm_full;
   logic [RPMF_W-SPEED_W:0]    rpm_high;
   logic signed [SPEED_W-1:0]  rpm_sat;
   stage_ctl_type              s4_ctl_ff;
   logic signed [SPEED_W-1:0]  s4_rpm_ff;

   always_comb begin
      prod_adj = s3_prod_ff + $signed({{(PROD_W-RPM_FRAC){1'b0}},
                                       {RPM_FRAC{s3_prod_ff[PROD_W-1]}}});
      rpm_full = prod_adj[PROD_W-1:RPM_FRAC];
      rpm_high = rpm_full[RPMF_W-1:SPEED_W-1];
      // In range when bit 15 and all bits above it agree
      if ((&rpm_high) || !(|rpm_high)) begin
         rpm_sat = rpm_full[SPEED_W-1:0];
      end else if (rpm_full[RPMF_W-1]) begin
         rpm_sat = {1'b1, {(SPEED_W-1){1'b0}}};
      end else begin
         rpm_sat = {1'b0, {(SPEED_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (s4_rdy && s3_vld_ff) begin
         s4_ctl_ff <= s3_ctl_ff;
         s4_rpm_ff <= rpm_sat;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: rpm average, reported speed and the result register
   // ---------------------------------------------------------------------
   logic                        s5_load;
   logic signed [SSUM_W-1:0]    ssum_next;
   logic signed [SSUM_W-1:0]    ssum_adj;
   logic signed [SPEED_W-1:0]   speed_ff, speed_in;
   logic signed [DRIVE_W-1:0]   drive_neg;
   logic [DUTY_W-1:0]           duty_ff;
   logic                        dir_fwd_ff, dir_rev_ff;

   assign s5_load = s5_rdy && s4_vld_ff;

   mesm_avg_ring #(
      .WIDTH      (SPEED_W),
      .LOG2_DEPTH (SPEED_AVG_LOG2)
   ) u_speed_avg (
      .clock    (clock),
      .reset    (reset),
      .clear    (1'b0),
      .push     (s5_load && s4_ctl_ff.tick),
      .value    (s4_rpm_ff),
      .sum_next (ssum_next)
   );

   always_comb begin
      ssum_adj  = ssum_next + $signed({{(SSUM_W-SPEED_AVG_LOG2){1'b0}},
                                       {SPEED_AVG_LOG2{ssum_next[SSUM_W-1]}}});
      drive_neg = -s4_ctl_ff.drive;
      priority if (s4_ctl_ff.clr) begin
         speed_in = '0;
      end else if (s4_ctl_ff.tick) begin
         speed_in = ssum_adj[SSUM_W-1:SPEED_AVG_LOG2];
      end else begin
         speed_in = speed_ff;
      end
   end

   // Reported speed is state, so it resets
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0;
      end else if (s5_load) begin
         speed_ff <= speed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_load) begin
         duty_ff    <= s4_ctl_ff.drive[DRIVE_W-1] ? drive_neg[DUTY_W-1:0]
                                                  : s4_ctl_ff.drive[DUTY_W-1:0];
         dir_fwd_ff <= !s4_ctl_ff.drive[DRIVE_W-1] && (s4_ctl_ff.drive != '0);
         dir_rev_ff <= s4_ctl_ff.drive[DRIVE_W-1];
      end
   end

   assign rsp_speed_rpm   = speed_ff;
   assign rsp_duty        = duty_ff;
   assign rsp_dir_forward = dir_fwd_ff;
   assign rsp_dir_reverse = dir_rev_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
`ifndef SYNTH
   // Zero duty exactly when neither direction line is driven
   a_duty_dir : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_duty == '0) == (!rsp_dir_forward && !rsp_dir_reverse)))
      else $error("duty and direction lines disagree");

   // Start from stop restarts the counter and the snapshot
   a_start_clear : assert property (@(posedge clock) disable iff (reset)
      (req_accept && start_drive) |=> ((count_ff == '0) && (snapshot_ff == '0)))
      else $error("start from stop did not clear the counter");

   // Input stalls only when every stage is full and the output is held
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_vld_ff && s2_vld_ff && s3_vld_ff && s4_vld_ff &&
                      s5_vld_ff && !rsp_ready))
      else $error("input stalled with room in the pipeline");

   // The clamp never lets -256 into the drive state
   a_drive_clamp : assert property (@(posedge clock) disable iff (reset)
      drive_ff != DRIVE_RAW_MIN)
      else $error("drive state out of range");
`endif

endmodule

[verif/motor_encoder_speed_meter_unit_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor_encoder_speed_meter_unit_tb
// Drives encoder edges, sample ticks and drive commands into the speed meter
// under random sender bursts and receiver stalls. A local model of the pulse
// counter, both moving averages, the rpm scaling and the drive clamp predicts
// every result beat, which is checked field by field in arrival order.
// rpm_scale is rewritten between phases while the block is drained.
// ---------------------------------------------------------------------------
module motor_encoder_speed_meter_unit_tb;
   import mesm_pkg::*;

   localparam int DELTA_DEPTH = 1 << DELTA_AVG_LOG2;
   localparam int SPEED_DEPTH = 1 << SPEED_AVG_LOG2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] RPM_SCALE_ADDR = {CSR_WORD_RPM_SCALE, 2'b00};
   localparam int PIPE_LATENCY = 5;

   typedef struct {
      logic signed [SPEED_W-1:0] speed;
      logic [DUTY_W-1:0]         duty;
      logic                      fwd;
      logic                      rev;
   } meter_reading_type;

   // DUT ports
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_command = CMD_EDGE;
   logic req_channel_b = 1'b0;
   logic signed [DRIVE_W-1:0] req_drive_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SPEED_W-1:0] rsp_speed_rpm;
   logic [DUTY_W-1:0] rsp_duty;
   logic rsp_dir_forward;
   logic rsp_dir_reverse;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // Speed meter model state
   logic [SCALE_W-1:0] rpm_scale_setting = SCALE_RESET;
   logic [31:0] pulse_count = '0;
   logic [31:0] last_snapshot = '0;
   longint delta_hist[DELTA_DEPTH] = '{default: 0};
   longint delta_sum = 0;
   int delta_pos = 0;
   longint speed_hist[SPEED_DEPTH] = '{default: 0};
   longint speed_sum = 0;
   int speed_pos = 0;
   logic signed [DRIVE_W-1:0] drive_level = '0;
   logic signed [SPEED_W-1:0] shown_speed = '0;

   meter_reading_type pending_readings[$];
   int mismatch_count = 0;
   int burst_left = 0;

   motor_encoder_speed_meter_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_channel_b   (req_channel_b),
      .req_drive_value (req_drive_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_speed_rpm   (rsp_speed_rpm),
      .rsp_duty        (rsp_duty),
      .rsp_dir_forward (rsp_dir_forward),
      .rsp_dir_reverse (rsp_dir_reverse),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // Advance the model by one item and return the reading it produces
   function automatic meter_reading_type step_speed_meter(input logic [1:0] cmd,
                                                          input logic chb,
                                                          input logic [DRIVE_W-1:0] drv);
      meter_reading_type r;
      logic [31:0] raw;
      longint delta;
      longint sc;
      longint rpm;
      logic signed [DRIVE_W-1:0] level;
      logic signed [DRIVE_W-1:0] mag;
      case (cmd)
         CMD_EDGE: begin
            pulse_count = chb ? pulse_count + 32'd1 : pulse_count - 32'd1;
         end
         CMD_TICK: begin
            // delta since last tick, read as 32-bit two's complement
            raw = pulse_count - last_snapshot;
            delta = longint'($signed(raw));
            last_snapshot = pulse_count;
            delta_sum = delta_sum + delta - delta_hist[delta_pos];
            delta_hist[delta_pos] = delta;
            delta_pos = (delta_pos + 1) % DELTA_DEPTH;
            // Q8.8 scaling, truncate toward zero, then saturate
            sc = longint'(rpm_scale_setting);
            rpm = ((delta_sum / DELTA_DEPTH) * sc) / 256;
            if (rpm > 32767) rpm = 32767;
            if (rpm < -32768) rpm = -32768;
            speed_sum = speed_sum + rpm - speed_hist[speed_pos];
            speed_hist[speed_pos] = rpm;
            speed_pos = (speed_pos + 1) % SPEED_DEPTH;
            shown_speed = SPEED_W'(speed_sum / SPEED_DEPTH);
         end
         CMD_DRIVE: begin
            level = drv;
            if (level == DRIVE_RAW_MIN) level = DRIVE_CLAMP;
            // start from stop: counter, pulse average and speed readout restart
            if (drive_level == 0 && level != 0) begin
               pulse_count = '0;
               last_snapshot = '0;
               delta_hist = '{default: 0};
               delta_sum = 0;
               delta_pos = 0;
               shown_speed = '0;
            end
            drive_level = level;
         end
         default: ;
      endcase
      mag = (drive_level < 0) ? -drive_level : drive_level;
      r.speed = shown_speed;
      r.duty = mag[DUTY_W-1:0];
      r.fwd = (drive_level > 0);
      r.rev = (drive_level < 0);
      return r;
   endfunction

   // Send one item; bursts of random length with random gaps between them
   task automatic send_item(input logic [1:0] cmd, input logic chb,
                            input logic [DRIVE_W-1:0] drv);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_channel_b <= chb;
      req_drive_value <= drv;
      do @(posedge clock); while (!req_ready);
      pending_readings.push_back(step_speed_meter(cmd, chb, drv));
   endtask

   // Stop sending and let every outstanding beat come back
   task automatic wait_drained;
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // APB write of rpm_scale, then read it back
   task automatic write_rpm_scale(input logic [SCALE_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= RPM_SCALE_ADDR;
      csr_pwdata <= {{(CSR_DATA_W-SCALE_W){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rpm_scale_setting = value;
      // read setup follows the write access directly
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata !== {{(CSR_DATA_W-SCALE_W){1'b0}}, value}) begin
         $display("%0t: rpm_scale readback mismatch, expected %0d, got %0d",
                  $time, value, csr_prdata);
         mismatch_count++;
      end
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [DRIVE_W-1:0] any_drive();
      return DRIVE_W'($urandom_range(0, (1 << DRIVE_W) - 1));
   endfunction

   // Quiet block: readout all zero, unused fields ignored
   task automatic test_idle_readout;
      send_item(CMD_UNUSED, 1'b1, 9'h1FF);
      send_item(CMD_UNUSED, 1'b0, 9'h0FF);
      send_item(CMD_TICK, 1'b1, 9'h155);
   endtask

   // Up and down counting, count wrap below zero, delta sign
   task automatic test_count_and_tick;
      repeat (3) send_item(CMD_EDGE, 1'b1, 9'h0AA);
      send_item(CMD_EDGE, 1'b0, 9'h155);
      send_item(CMD_TICK, 1'b0, 9'h1FF);
      send_item(CMD_TICK, 1'b1, 9'h000);
      repeat (5) send_item(CMD_EDGE, 1'b0, 9'h100);
      send_item(CMD_TICK, 1'b0, 9'h0FF);
   endtask

   // Drive levels, the -256 clamp, stop-to-moving restart
   task automatic test_drive_levels;
      send_item(CMD_EDGE, 1'b1, 9'h000);
      send_item(CMD_DRIVE, 1'b0, 9'sd255);
      send_item(CMD_DRIVE, 1'b1, DRIVE_RAW_MIN);
      send_item(CMD_DRIVE, 1'b0, 9'sd0);
      send_item(CMD_EDGE, 1'b1, 9'h000);
      send_item(CMD_DRIVE, 1'b1, -9'sd1);
      send_item(CMD_TICK, 1'b0, 9'h000);
      send_item(CMD_DRIVE, 1'b0, 9'sd1);
      send_item(CMD_DRIVE, 1'b0, 9'sd0);
      send_item(CMD_DRIVE, 1'b0, 9'sd128);
   endtask

   // Top rpm_scale: large readings of both signs, restart between them
   task automatic test_full_scale;
      wait_drained;
      write_rpm_scale(16'hFFFF);
      send_item(CMD_DRIVE, 1'b0, 9'sd0);
      send_item(CMD_DRIVE, 1'b0, 9'sd1);
      repeat (2) begin
         repeat (40) send_item(CMD_EDGE, 1'b1, any_drive());
         send_item(CMD_TICK, 1'b0, any_drive());
      end
      send_item(CMD_DRIVE, 1'b0, 9'sd0);
      send_item(CMD_DRIVE, 1'b0, -9'sd1);
      repeat (2) begin
         repeat (40) send_item(CMD_EDGE, 1'b0, any_drive());
         send_item(CMD_TICK, 1'b1, any_drive());
      end
      send_item(CMD_DRIVE, 1'b0, 9'sd0);
   endtask

   // Random traffic: mostly edge runs closed by a tick, some drives and noise
   task automatic test_random_traffic;
      logic [SCALE_W-1:0] scales[6];
      int sent;
      int pick;
      int n;
      logic dir;
      logic [DRIVE_W-1:0] drv;
      scales = '{16'd0, 16'hFFFF, 16'd1, 16'd256,
                 SCALE_W'($urandom), SCALE_W'($urandom_range(0, 4000))};
      foreach (scales[p]) begin
         wait_drained;
         write_rpm_scale(scales[p]);
         sent = 0;
         while (sent < 65) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
               n = $urandom_range(0, 40);
               dir = 1'($urandom_range(0, 1));
               repeat (n) begin
                  send_item(CMD_EDGE, ($urandom_range(0, 9) == 0) ? ~dir : dir,
                            any_drive());
               end
               send_item(CMD_TICK, 1'($urandom_range(0, 1)), any_drive());
               sent += n + 1;
            end else if (pick < 82) begin
               case ($urandom_range(0, 6))
                  0, 1:    drv = 9'sd0;
                  2:       drv = 9'sd255;
                  3:       drv = DRIVE_RAW_MIN;
                  4:       drv = ($urandom_range(0, 1)) ? 9'sd1 : -9'sd1;
                  default: drv = any_drive();
               endcase
               send_item(CMD_DRIVE, 1'($urandom_range(0, 1)), drv);
               sent++;
            end else if (pick < 90) begin
               n = $urandom_range(1, 4);
               repeat (n) send_item(CMD_TICK, 1'($urandom_range(0, 1)), any_drive());
               sent += n;
            end else if (pick < 95) begin
               send_item(CMD_UNUSED, 1'($urandom_range(0, 1)), any_drive());
               sent++;
            end else begin
               n = $urandom_range(1, 10);
               repeat (n) begin
                  send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            any_drive());
               end
               sent += n;
            end
         end
      end
   endtask

   // Receiver: ready pattern switches between modes at random intervals
   int stall_mode = 0;
   int stall_left = 0;
   int stall_phase = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 120);
         stall_phase = 0;
      end else begin
         stall_left--;
         stall_phase++;
      end
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 99) < 65);
         2:       rsp_ready <= ((stall_phase % 4) != 3);
         default: rsp_ready <= ((stall_phase % 16) >= 10);
      endcase
   end

   // Result check against the oldest pending reading
   always @(posedge clock) begin
      meter_reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: result beat with none pending, speed %0d duty %0d",
                     $time, rsp_speed_rpm, rsp_duty);
            mismatch_count++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_speed_rpm !== want.speed) begin
               $display("%0t: speed_rpm mismatch, expected %0d, got %0d",
                        $time, want.speed, rsp_speed_rpm);
               mismatch_count++;
            end
            if (rsp_duty !== want.duty) begin
               $display("%0t: duty mismatch, expected %0d, got %0d",
                        $time, want.duty, rsp_duty);
               mismatch_count++;
            end
            if (rsp_dir_forward !== want.fwd) begin
               $display("%0t: dir_forward mismatch, expected %0b, got %0b",
                        $time, want.fwd, rsp_dir_forward);
               mismatch_count++;
            end
            if (rsp_dir_reverse !== want.rev) begin
               $display("%0t: dir_reverse mismatch, expected %0b, got %0b",
                        $time, want.rev, rsp_dir_reverse);
               mismatch_count++;
            end
         end
      end
   end

   // Test sequence
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_readout();
      test_count_and_tick();
      test_drive_levels();
      test_full_scale();
      test_random_traffic();
      wait_drained;
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS motor_encoder_speed_meter_unit");
      end else begin
         $display("FAIL motor_encoder_speed_meter_unit");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5000000;
      $display("FAIL motor_encoder_speed_meter_unit");
      $finish;
   end

endmodule
